// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the zoom/distance focus table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// An implication checked in the same cycle outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/zdft_pkg.sv
// Types and constants of the zoom/distance focus table.
package zdft_pkg;

    localparam logic [1:0] OP_UPSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NODATA = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int DIV_NW = 32;
    localparam int DIV_DW = 16;

    localparam logic [DIV_NW-1:0] DIOPTER_NUM = 32'd1024000;

    typedef struct packed {
        logic        dir;
        logic [15:0] zoom;
        logic [15:0] diop;
    } t_key;

    typedef struct packed {
        logic               acc;
        logic signed [15:0] offset;
        logic [15:0]        spread;
    } t_val;

endpackage

// File: hdl/zoom_distance_focus_table.sv
// Top level of the zoom/distance focus calibration table with two-level interpolation.
`include "assert_macros.svh"
// The block keeps up to MAX_POINTS calibration points in two tables (keys and values,
// each with a write port and a registered read port) and serves one command at a
// time: start is taken while busy is low, and the single result word appears for
// exactly one cycle with o_strobe high; the receiver cannot stall it, so it must take
// the word in that cycle. An upsert walks the filled part of the table once. A clear
// or an ignored code, or a lookup with no accepted points, goes straight to the result
// word. Any other lookup converts a nonzero distance into a diopter with a bit-serial
// divider, walks the table once to find the bracketing diopter layers, walks it once
// per layer to find the bracketing zoom points, runs one division per interpolation
// that needs it and ends with the multiply and rounding steps. The table walks and the
// divider, shared by all divisions, take most of the time. The fill count marks the valid
// part of the table, so reset and clear take effect at once and no clearing pass exists.
module zoom_distance_focus_table import zdft_pkg::*; #(
    parameter int MAX_POINTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [15:0]        i_zoom_ratio,
    input  logic [15:0]        i_point_diopter,
    input  logic [15:0]        i_distance_mm,
    input  logic               i_zoom_dir,
    input  logic signed [15:0] i_focus_offset,
    input  logic [15:0]        i_spread,
    input  logic               i_entry_accepted,
    input  logic [8:0]         i_strength,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_applied_offset,
    output logic [15:0]        o_spread_out,
    output logic               o_table_loaded
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_UPSCAN = 5'd1;
    localparam logic [4:0] S_UPWR   = 5'd2;
    localparam logic [4:0] S_DIVGO  = 5'd3;
    localparam logic [4:0] S_DIVWT  = 5'd4;
    localparam logic [4:0] S_DSCAN  = 5'd5;
    localparam logic [4:0] S_LSCAN  = 5'd6;
    localparam logic [4:0] S_RDA    = 5'd7;
    localparam logic [4:0] S_RDB    = 5'd8;
    localparam logic [4:0] S_RDW    = 5'd9;
    localparam logic [4:0] S_LMUL   = 5'd10;
    localparam logic [4:0] S_FMUL1  = 5'd11;
    localparam logic [4:0] S_FMUL2  = 5'd12;
    localparam logic [4:0] S_FIN    = 5'd13;
    localparam logic [4:0] S_OUT    = 5'd14;

    localparam logic [1:0] DS_QD = 2'd0;
    localparam logic [1:0] DS_TZ = 2'd1;
    localparam logic [1:0] DS_TD = 2'd2;

    // Control state.
    logic [4:0]    r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_acc_cnt;
    logic [CW-1:0] r_idx;
    logic          r_dv;
    logic          r_strobe;

    // Latched command word.
    logic [1:0]         r_op;
    logic [15:0]        r_zoom;
    logic [15:0]        r_diop;
    logic               r_dir;
    logic signed [15:0] r_foff;
    logic [15:0]        r_spread;
    logic               r_acc;
    logic [8:0]         r_str;

    // Tables and their read side.
    t_key          key_mem [MAX_POINTS];
    t_val          val_mem [MAX_POINTS];
    t_key          r_rkey;
    t_val          r_rval;
    logic [IW-1:0] r_didx;

    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic          r_facc;

    logic [15:0] r_qd;
    logic        r_have, r_haslo, r_hashi;
    logic [15:0] r_dmin, r_dmax, r_dlo, r_dhi, r_la, r_lb;
    logic        r_layer;

    logic          r_zhave, r_hzlo, r_hzhi;
    logic [IW-1:0] r_imin, r_imax, r_ilo, r_ihi, r_ia, r_ib;
    logic [15:0]   r_zmin, r_zmax, r_zlo, r_zhi, r_za, r_zb;
    t_val          r_va, r_vb;

    logic [1:0]        r_dsel;
    logic [DIV_NW-1:0] r_dnum;
    logic [DIV_DW-1:0] r_dden;
    logic [15:0]       r_tz, r_td;

    logic signed [33:0] r_da, r_db, r_sla, r_slb;
    logic signed [51:0] r_r, r_s;
    logic [32:0]        r_diff;
    logic [30:0]        r_tt;
    logic signed [61:0] r_rs;
    logic [63:0]        r_dp;

    logic [1:0]         r_res_status;
    logic signed [15:0] r_res_off;
    logic [15:0]        r_res_spr;
    logic [1:0]         r_o_status;
    logic signed [15:0] r_o_off;
    logic [15:0]        r_o_spr;
    logic               r_o_loaded;

    // Divider hookup.
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;

    zdft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Table walk: one address issued per cycle, its data is looked at in the next cycle.
    logic          in_scan, issuing, scan_end;
    logic [IW-1:0] rd_addr;
    logic          usable;
    logic [15:0]   tdiop;

    assign in_scan  = (r_state == S_UPSCAN) || (r_state == S_DSCAN) || (r_state == S_LSCAN);
    assign issuing  = in_scan && (r_idx < r_count);
    assign scan_end = in_scan && !issuing && !r_dv;
    assign rd_addr  = issuing ? r_idx[IW-1:0] : ((r_state == S_RDB) ? r_ib : r_ia);
    assign usable   = r_dv && r_rval.acc && (r_rkey.dir == r_dir);
    assign tdiop    = r_layer ? r_lb : r_la;

    // Write side: only the upsert commit writes.
    logic          up_full, we_key, we_val;
    logic [IW-1:0] waddr;
    t_key          wkey;
    t_val          wval;

    assign up_full = r_count == CW'(MAX_POINTS);
    assign we_val  = (r_state == S_UPWR) && (r_found || !up_full);
    assign we_key  = (r_state == S_UPWR) && !r_found && !up_full;
    assign waddr   = r_found ? r_fidx : r_count[IW-1:0];
    assign wkey    = '{dir: r_dir, zoom: r_zoom, diop: r_diop};
    assign wval    = '{acc: r_acc, offset: r_foff, spread: r_spread};

    always_ff @(posedge i_clk) begin
        if (we_key) begin
            key_mem[waddr] <= wkey;
        end
        if (we_val) begin
            val_mem[waddr] <= wval;
        end
        r_rkey <= key_mem[rd_addr];
        r_rval <= val_mem[rd_addr];
        r_didx <= rd_addr;
    end

    // Layer value: interpolation over zoom between the two chosen points.
    logic signed [16:0] lm_odif, lm_sdif, lm_tzs;
    logic signed [33:0] lm_oprod, lm_sprod, lm_d, lm_s;

    always_comb begin
        lm_tzs   = {1'b0, r_tz};
        lm_odif  = {r_vb.offset[15], r_vb.offset} - {r_va.offset[15], r_va.offset};
        lm_sdif  = {1'b0, r_vb.spread} - {1'b0, r_va.spread};
        lm_oprod = lm_odif * lm_tzs;
        lm_sprod = lm_sdif * lm_tzs;
        lm_d     = {{2{r_va.offset[15]}}, r_va.offset, 16'b0} + lm_oprod;
        lm_s     = {2'b0, r_va.spread, 16'b0} + lm_sprod;
    end

    // Interpolation across the two layers.
    logic signed [34:0] f_dd, f_neg, f_sdif;
    logic signed [16:0] f_td;
    logic signed [51:0] f_rprod, f_sprod, f_r, f_s;
    logic [16:0]        f_comp;
    logic [32:0]        f_ttw;

    always_comb begin
        f_td    = {1'b0, r_td};
        f_dd    = {r_db[33], r_db} - {r_da[33], r_da};
        f_neg   = -f_dd;
        f_sdif  = {r_slb[33], r_slb} - {r_sla[33], r_sla};
        f_rprod = f_dd * f_td;
        f_sprod = f_sdif * f_td;
        f_r     = {{2{r_da[33]}}, r_da, 16'b0} + f_rprod;
        f_s     = {{2{r_sla[33]}}, r_sla, 16'b0} + f_sprod;
        f_comp  = 17'h10000 - {1'b0, r_td};
        f_ttw   = r_td * f_comp;
    end

    logic [8:0]         f2_strc;
    logic signed [9:0]  f2_str;
    logic signed [61:0] f2_rs;
    logic [63:0]        f2_dp;

    always_comb begin
        f2_strc = (r_str > 9'd256) ? 9'd256 : r_str;
        f2_str  = {1'b0, f2_strc};
        f2_rs   = r_r * f2_str;
        f2_dp   = r_diff * r_tt;
    end

    // Rounding and saturation of both results.
    logic [61:0] fin_mag, fin_sum;
    logic [21:0] fin_rnd;
    logic        fin_big;
    logic [15:0] fin_off;
    logic [51:0] fin_sc;
    logic [57:0] fin_acc, fin_rs;
    logic [25:0] fin_hi;
    logic [15:0] fin_spr;

    always_comb begin
        fin_mag = r_rs[61] ? 62'(-r_rs) : 62'(r_rs);
        fin_sum = fin_mag + {22'b0, 1'b1, 39'b0};
        fin_rnd = fin_sum[61:40];
        fin_big = fin_rnd >= 22'd32768;
        if (r_rs[61]) begin
            fin_off = fin_big ? 16'h8000 : 16'(~fin_rnd[15:0] + 16'd1);
        end else begin
            fin_off = fin_big ? 16'h7FFF : fin_rnd[15:0];
        end
        fin_sc  = r_s[51] ? 52'd0 : 52'(r_s);
        fin_acc = {6'b0, fin_sc} + {2'b0, r_dp[63:8]};
        fin_rs  = fin_acc + {26'b0, 1'b1, 31'b0};
        fin_hi  = fin_rs[57:32];
        fin_spr = (|fin_hi[25:16]) ? 16'hFFFF : fin_hi[15:0];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_acc_cnt <= '0;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_dv     <= issuing;
            r_strobe <= (r_state == S_OUT);
            if (issuing) begin
                r_idx <= r_idx + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_operation;
                        r_zoom   <= i_zoom_ratio;
                        r_diop   <= i_point_diopter;
                        r_dir    <= i_zoom_dir;
                        r_foff   <= i_focus_offset;
                        r_spread <= i_spread;
                        r_acc    <= i_entry_accepted;
                        r_str    <= i_strength;
                        r_res_off    <= '0;
                        r_res_spr    <= '0;
                        r_idx    <= '0;
                        case (i_operation)
                            OP_UPSERT: begin
                                r_res_status <= ST_OK;
                                r_found <= 1'b0;
                                r_state <= S_UPSCAN;
                            end
                            OP_LOOKUP: begin
                                r_have  <= 1'b0;
                                r_haslo <= 1'b0;
                                r_hashi <= 1'b0;
                                if (r_acc_cnt == '0) begin
                                    r_res_status <= ST_NODATA;
                                    r_state      <= S_OUT;
                                end else if (i_distance_mm == 16'd0) begin
                                    r_res_status <= ST_OK;
                                    r_qd    <= '0;
                                    r_state <= S_DSCAN;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_dnum  <= DIOPTER_NUM;
                                    r_dden  <= i_distance_mm;
                                    r_dsel  <= DS_QD;
                                    r_state <= S_DIVGO;
                                end
                            end
                            OP_CLEAR: begin
                                r_res_status <= ST_OK;
                                r_count   <= '0;
                                r_acc_cnt <= '0;
                                r_state   <= S_OUT;
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_UPSCAN: begin
                    if (r_dv && !r_found && (r_rkey == wkey)) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_didx;
                        r_facc  <= r_rval.acc;
                    end
                    if (scan_end) begin
                        r_state <= S_UPWR;
                    end
                end
                S_UPWR: begin
                    if (r_found) begin
                        r_acc_cnt <= r_acc_cnt - CW'(r_facc) + CW'(r_acc);
                    end else if (up_full) begin
                        r_res_status <= ST_FULL;
                    end else begin
                        r_count   <= r_count + 1'b1;
                        r_acc_cnt <= r_acc_cnt + CW'(r_acc);
                    end
                    r_state <= S_OUT;
                end
                S_DIVGO: begin
                    r_state <= S_DIVWT;
                end
                S_DIVWT: begin
                    if (div_done) begin
                        case (r_dsel)
                            DS_QD: begin
                                r_qd    <= (|div_quo[31:16]) ? 16'hFFFF : div_quo[15:0];
                                r_idx   <= '0;
                                r_state <= S_DSCAN;
                            end
                            DS_TZ: begin
                                r_tz    <= div_quo[15:0];
                                r_state <= S_LMUL;
                            end
                            default: begin
                                r_td    <= div_quo[15:0];
                                r_state <= S_FMUL1;
                            end
                        endcase
                    end
                end
                S_DSCAN: begin
                    if (usable) begin
                        r_have <= 1'b1;
                        if (!r_have || r_rkey.diop < r_dmin) r_dmin <= r_rkey.diop;
                        if (!r_have || r_rkey.diop > r_dmax) r_dmax <= r_rkey.diop;
                        if (r_rkey.diop <= r_qd && (!r_haslo || r_rkey.diop > r_dlo)) begin
                            r_dlo   <= r_rkey.diop;
                            r_haslo <= 1'b1;
                        end
                        if (r_rkey.diop > r_qd && (!r_hashi || r_rkey.diop < r_dhi)) begin
                            r_dhi   <= r_rkey.diop;
                            r_hashi <= 1'b1;
                        end
                    end
                    if (scan_end) begin
                        if (!r_have) begin
                            r_res_status <= ST_NODATA;
                            r_state      <= S_OUT;
                        end else begin
                            if (r_qd <= r_dmin) begin
                                r_la <= r_dmin;
                                r_lb <= r_dmin;
                            end else if (r_qd >= r_dmax) begin
                                r_la <= r_dmax;
                                r_lb <= r_dmax;
                            end else begin
                                r_la <= r_dlo;
                                r_lb <= r_dhi;
                            end
                            r_layer <= 1'b0;
                            r_zhave <= 1'b0;
                            r_hzlo  <= 1'b0;
                            r_hzhi  <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_LSCAN;
                        end
                    end
                end
                S_LSCAN: begin
                    if (usable && r_rkey.diop == tdiop) begin
                        r_zhave <= 1'b1;
                        if (!r_zhave || r_rkey.zoom < r_zmin) begin
                            r_zmin <= r_rkey.zoom;
                            r_imin <= r_didx;
                        end
                        if (!r_zhave || r_rkey.zoom > r_zmax) begin
                            r_zmax <= r_rkey.zoom;
                            r_imax <= r_didx;
                        end
                        if (r_rkey.zoom <= r_zoom && (!r_hzlo || r_rkey.zoom > r_zlo)) begin
                            r_zlo  <= r_rkey.zoom;
                            r_ilo  <= r_didx;
                            r_hzlo <= 1'b1;
                        end
                        if (r_rkey.zoom > r_zoom && (!r_hzhi || r_rkey.zoom < r_zhi)) begin
                            r_zhi  <= r_rkey.zoom;
                            r_ihi  <= r_didx;
                            r_hzhi <= 1'b1;
                        end
                    end
                    if (scan_end) begin
                        if (r_zoom <= r_zmin) begin
                            r_ia <= r_imin;
                            r_ib <= r_imin;
                            r_za <= r_zmin;
                            r_zb <= r_zmin;
                        end else if (r_zoom >= r_zmax) begin
                            r_ia <= r_imax;
                            r_ib <= r_imax;
                            r_za <= r_zmax;
                            r_zb <= r_zmax;
                        end else begin
                            r_ia <= r_ilo;
                            r_ib <= r_ihi;
                            r_za <= r_zlo;
                            r_zb <= r_zhi;
                        end
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_va    <= r_rval;
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_vb <= r_rval;
                    if (r_ia != r_ib) begin
                        r_dnum  <= {16'(r_zoom - r_za), 16'b0};
                        r_dden  <= r_zb - r_za;
                        r_dsel  <= DS_TZ;
                        r_state <= S_DIVGO;
                    end else begin
                        r_tz    <= '0;
                        r_state <= S_LMUL;
                    end
                end
                S_LMUL: begin
                    if (!r_layer) begin
                        r_da  <= lm_d;
                        r_sla <= lm_s;
                        if (r_lb != r_la) begin
                            r_layer <= 1'b1;
                            r_zhave <= 1'b0;
                            r_hzlo  <= 1'b0;
                            r_hzhi  <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_LSCAN;
                        end else begin
                            r_db    <= lm_d;
                            r_slb   <= lm_s;
                            r_td    <= '0;
                            r_state <= S_FMUL1;
                        end
                    end else begin
                        r_db    <= lm_d;
                        r_slb   <= lm_s;
                        r_dnum  <= {16'(r_qd - r_la), 16'b0};
                        r_dden  <= r_lb - r_la;
                        r_dsel  <= DS_TD;
                        r_state <= S_DIVGO;
                    end
                end
                S_FMUL1: begin
                    r_r     <= f_r;
                    r_s     <= f_s;
                    r_diff  <= f_dd[34] ? f_neg[32:0] : f_dd[32:0];
                    r_tt    <= f_ttw[30:0];
                    r_state <= S_FMUL2;
                end
                S_FMUL2: begin
                    r_rs    <= f2_rs;
                    r_dp    <= f2_dp;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res_off <= fin_off;
                    r_res_spr <= fin_spr;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    r_o_status <= r_res_status;
                    r_o_off    <= r_res_off;
                    r_o_spr    <= r_res_spr;
                    r_o_loaded <= r_acc_cnt != '0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = r_state != S_IDLE;
    assign o_strobe         = r_strobe;
    assign o_status         = r_o_status;
    assign o_applied_offset = r_o_off;
    assign o_spread_out     = r_o_spr;
    assign o_table_loaded   = r_o_loaded;

    `ASSERT_CLK(a_count_in_range, i_clk, i_rst_n, r_count <= CW'(MAX_POINTS), "fill count beyond table depth")
    `ASSERT_CLK(a_acc_le_count, i_clk, i_rst_n, r_acc_cnt <= r_count, "accepted count above fill count")
    `ASSERT_IMPL(a_full_status, i_clk, i_rst_n, o_strobe && (o_status == ST_FULL), r_count == CW'(MAX_POINTS), "full status while table has room")
    `ASSERT_IMPL(a_strobe_after_work, i_clk, i_rst_n, o_strobe, $past(busy), "result word without a command in progress")

endmodule

// File: hdl/zdft_div.sv
// Restoring divider that produces one quotient bit per cycle.
module zdft_div import zdft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo
);

    localparam int NCW = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [NCW-1:0]    r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW:0]   shifted;
    logic              ge;

    assign shifted = {r_rem, r_q[DIV_NW-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
            end else if (r_busy) begin
                r_rem <= ge ? DIV_DW'(shifted - {1'b0, r_den}) : shifted[DIV_DW-1:0];
                r_q   <= {r_q[DIV_NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NCW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: bench/zdft_checker.sv
// Checker for the zoom/distance focus table: predicts each result word and compares it.
`timescale 1ns / 1ps
module zdft_checker import zdft_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_operation,
    input  logic [15:0]        i_zoom_ratio,
    input  logic [15:0]        i_point_diopter,
    input  logic [15:0]        i_distance_mm,
    input  logic               i_zoom_dir,
    input  logic signed [15:0] i_focus_offset,
    input  logic [15:0]        i_spread,
    input  logic               i_entry_accepted,
    input  logic [8:0]         i_strength,
    input  logic               i_strobe,
    input  logic [1:0]         i_status,
    input  logic signed [15:0] i_applied_offset,
    input  logic [15:0]        i_spread_out,
    input  logic               i_table_loaded,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int POINTS = 32;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] offset;
        logic [15:0]        spread;
        logic               loaded;
    } t_focus_word;

    // Shadow copy of the calibration table.
    t_key        cal_key [POINTS];
    t_val        cal_val [POINTS];
    int unsigned fill_count;
    int unsigned acc_count;
    t_focus_word expected_words[$];

    function automatic bit usable(int i, logic dir);
        return cal_val[i].acc && cal_key[i].dir == dir;
    endfunction

    // Appends one predicted word at the tail of the queue.
    function automatic void queue_word(t_focus_word w);
        expected_words = {expected_words, w};
    endfunction

    // Interpolation over zoom within one diopter layer.
    function automatic void layer_interp(logic dir, logic [15:0] diop, logic [15:0] ratio,
                                         output longint d_out, output longint s_out);
        int     imin, imax, ilo, ihi, a, b;
        longint tz, za, zb, oa, ob, sa, sb;
        imin = -1; imax = -1; ilo = -1; ihi = -1; tz = 0;
        for (int i = 0; i < fill_count; i++) begin
            if (!usable(i, dir) || cal_key[i].diop != diop) continue;
            if (imin < 0 || cal_key[i].zoom < cal_key[imin].zoom) imin = i;
            if (imax < 0 || cal_key[i].zoom > cal_key[imax].zoom) imax = i;
            if (cal_key[i].zoom <= ratio && (ilo < 0 || cal_key[i].zoom > cal_key[ilo].zoom))
                ilo = i;
            if (cal_key[i].zoom > ratio && (ihi < 0 || cal_key[i].zoom < cal_key[ihi].zoom))
                ihi = i;
        end
        if (imin < 0) begin
            d_out = 0;
            s_out = 0;
            return;
        end
        if (ratio <= cal_key[imin].zoom) begin
            a = imin; b = imin;
        end else if (ratio >= cal_key[imax].zoom) begin
            a = imax; b = imax;
        end else begin
            a = ilo; b = ihi;
        end
        if (a != b) begin
            za = cal_key[a].zoom;
            zb = cal_key[b].zoom;
            tz = ((longint'(ratio) - za) * 65536) / (zb - za);
        end
        oa = cal_val[a].offset; ob = cal_val[b].offset;
        sa = cal_val[a].spread; sb = cal_val[b].spread;
        d_out = oa * 65536 + (ob - oa) * tz;
        s_out = sa * 65536 + (sb - sa) * tz;
    endfunction

    function automatic t_focus_word predict_word(logic [1:0] op, logic [15:0] zoom,
            logic [15:0] diop, logic [15:0] distance, logic dir, logic signed [15:0] offs,
            logic [15:0] spr, logic acc, logic [8:0] strength);
        t_focus_word w;
        int          found;
        bit          have, has_lo, has_hi;
        longint      qd, dmin, dmax, dlo, dhi, la, lb, da, db, sa, sb, td, r, mag, s, str;
        longint unsigned diff, acc_sum;
        w = '0;
        w.status = ST_OK;
        case (op)
            OP_UPSERT: begin
                found = -1;
                for (int i = 0; i < fill_count; i++)
                    if (cal_key[i] == {dir, zoom, diop}) begin
                        found = i;
                        break;
                    end
                if (found >= 0) begin
                    if (cal_val[found].acc) acc_count--;
                    cal_val[found] = {acc, offs, spr};
                    if (acc) acc_count++;
                end else if (fill_count >= POINTS) begin
                    w.status = ST_FULL;
                end else begin
                    cal_key[fill_count] = {dir, zoom, diop};
                    cal_val[fill_count] = {acc, offs, spr};
                    fill_count++;
                    if (acc) acc_count++;
                end
            end
            OP_LOOKUP: begin
                qd = 0;
                if (distance != 0) begin
                    qd = 1024000 / longint'(distance);
                    if (qd > 65535) qd = 65535;
                end
                have = 0; has_lo = 0; has_hi = 0;
                dmin = 0; dmax = 0; dlo = 0; dhi = 0;
                for (int i = 0; i < fill_count; i++) begin
                    if (!usable(i, dir)) continue;
                    if (!have) begin
                        dmin = cal_key[i].diop; dmax = dmin; have = 1;
                    end
                    if (cal_key[i].diop < dmin) dmin = cal_key[i].diop;
                    if (cal_key[i].diop > dmax) dmax = cal_key[i].diop;
                    if (cal_key[i].diop <= qd && (!has_lo || cal_key[i].diop > dlo)) begin
                        dlo = cal_key[i].diop; has_lo = 1;
                    end
                    if (cal_key[i].diop > qd && (!has_hi || cal_key[i].diop < dhi)) begin
                        dhi = cal_key[i].diop; has_hi = 1;
                    end
                end
                if (acc_count == 0 || !have) begin
                    w.status = ST_NODATA;
                end else begin
                    if (qd <= dmin) begin
                        la = dmin; lb = dmin;
                    end else if (qd >= dmax) begin
                        la = dmax; lb = dmax;
                    end else begin
                        la = dlo; lb = dhi;
                    end
                    td = 0;
                    layer_interp(dir, la[15:0], zoom, da, sa);
                    if (lb != la) begin
                        layer_interp(dir, lb[15:0], zoom, db, sb);
                        td = ((qd - la) * 65536) / (lb - la);
                    end else begin
                        db = da; sb = sa;
                    end
                    str = (strength > 256) ? 256 : strength;
                    r = (da * 65536 + (db - da) * td) * str;
                    mag = (r < 0) ? -r : r;
                    mag = (mag + (longint'(1) << 39)) / (longint'(1) << 40);
                    r = (r < 0) ? -mag : mag;
                    if (r > 32767) r = 32767;
                    if (r < -32768) r = -32768;
                    w.offset = r[15:0];
                    s = sa * 65536 + (sb - sa) * td;
                    if (s < 0) s = 0;
                    diff = (db >= da) ? db - da : da - db;
                    acc_sum = longint'(unsigned'(s))
                              + ((diff * longint'(unsigned'(td * (65536 - td)))) >> 8);
                    acc_sum = (acc_sum + (64'd1 << 31)) >> 32;
                    w.spread = (acc_sum > 65535) ? 16'hFFFF : acc_sum[15:0];
                end
            end
            OP_CLEAR: begin
                fill_count = 0;
                acc_count = 0;
            end
            default: ;
        endcase
        w.loaded = (acc_count != 0);
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_focus_word got, want;
        if (!i_rst_n) begin
            fill_count = 0;
            acc_count = 0;
            expected_words.delete();
            o_errors <= 0;
        end else begin
            if (i_strobe) begin
                got = {i_status, i_applied_offset, i_spread_out, i_table_loaded};
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected: %h", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status || got.offset !== want.offset ||
                        got.spread !== want.spread || got.loaded !== want.loaded) begin
                        $display({"%0t: mismatch expected st=%0d off=%0d spr=%0d ld=%0d,",
                                  " got st=%0d off=%0d spr=%0d ld=%0d"},
                                 $realtime, want.status, want.offset, want.spread, want.loaded,
                                 got.status, got.offset, got.spread, got.loaded);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                queue_word(predict_word(i_operation, i_zoom_ratio,
                    i_point_diopter, i_distance_mm, i_zoom_dir, i_focus_offset, i_spread,
                    i_entry_accepted, i_strength));
        end
        o_pending <= expected_words.size();
    end
endmodule

// File: bench/tb_zoom_distance_focus_table.sv
// Testbench top for the zoom/distance focus table: drives command words and gives the verdict.
`timescale 1ns / 1ps
module tb_zoom_distance_focus_table import zdft_pkg::*;;
    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int RANDOM_WORDS = 1095;
    localparam int CALM_TAIL    = 150;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_operation = '0;
    logic [15:0]        i_zoom_ratio = '0;
    logic [15:0]        i_point_diopter = '0;
    logic [15:0]        i_distance_mm = '0;
    logic               i_zoom_dir = 1'b0;
    logic signed [15:0] i_focus_offset = '0;
    logic [15:0]        i_spread = '0;
    logic               i_entry_accepted = 1'b0;
    logic [8:0]         i_strength = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic signed [15:0] o_applied_offset;
    logic [15:0]        o_spread_out;
    logic               o_table_loaded;
    int                 mismatch_count;
    int                 words_in_flight;

    // Small pools of zooms and diopters, so that upserts often hit existing keys and
    // lookups find several layers with several zoom points each.
    logic [15:0] zoom_pool [8] = '{16'h0100, 16'h0180, 16'h0200, 16'h0400,
                                   16'h0800, 16'h1000, 16'h0000, 16'hFFFF};
    logic [15:0] diop_pool [6] = '{16'h0000, 16'h0200, 16'h0400, 16'h0A00,
                                   16'h2000, 16'hFFFF};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    zoom_distance_focus_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_zoom_ratio(i_zoom_ratio),
        .i_point_diopter(i_point_diopter), .i_distance_mm(i_distance_mm),
        .i_zoom_dir(i_zoom_dir), .i_focus_offset(i_focus_offset), .i_spread(i_spread),
        .i_entry_accepted(i_entry_accepted), .i_strength(i_strength),
        .o_strobe(o_strobe), .o_status(o_status), .o_applied_offset(o_applied_offset),
        .o_spread_out(o_spread_out), .o_table_loaded(o_table_loaded)
    );

    zdft_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_operation(i_operation), .i_zoom_ratio(i_zoom_ratio),
        .i_point_diopter(i_point_diopter), .i_distance_mm(i_distance_mm),
        .i_zoom_dir(i_zoom_dir), .i_focus_offset(i_focus_offset), .i_spread(i_spread),
        .i_entry_accepted(i_entry_accepted), .i_strength(i_strength),
        .i_strobe(o_strobe), .i_status(o_status), .i_applied_offset(o_applied_offset),
        .i_spread_out(o_spread_out), .i_table_loaded(o_table_loaded),
        .o_errors(mismatch_count), .o_pending(words_in_flight)
    );

    // Present one command word and hold start until the block takes it. Start is left
    // high afterwards; the caller lowers it only when an idle gap follows.
    task automatic issue_word(logic [1:0] op, logic [15:0] zoom, logic [15:0] diop,
                              logic [15:0] distance, logic dir, logic [15:0] offs,
                              logic [15:0] spr, logic acc, logic [8:0] strength);
        i_operation      <= op;
        i_zoom_ratio     <= zoom;
        i_point_diopter  <= diop;
        i_distance_mm    <= distance;
        i_zoom_dir       <= dir;
        i_focus_offset   <= offs;
        i_spread         <= spr;
        i_entry_accepted <= acc;
        i_strength       <= strength;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic upsert(logic [15:0] zoom, logic [15:0] diop, logic dir,
                          logic [15:0] offs, logic [15:0] spr, logic acc);
        issue_word(OP_UPSERT, zoom, diop, 16'($urandom), dir, offs, spr, acc,
                   9'($urandom));
    endtask

    task automatic lookup(logic [15:0] zoom, logic [15:0] distance, logic dir,
                          logic [8:0] strength);
        issue_word(OP_LOOKUP, zoom, 16'($urandom), distance, dir, 16'($urandom),
                   16'($urandom), 1'($urandom), strength);
    endtask

    // Random word, weighted toward upserts on pooled keys and lookups near them.
    task automatic random_word();
        int          pick;
        logic [15:0] zoom, diop, distance;
        pick = $urandom_range(0, 99);
        zoom = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                           : zoom_pool[$urandom_range(0, 7)];
        diop = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                           : diop_pool[$urandom_range(0, 5)];
        case ($urandom_range(0, 3))
            0: distance = 16'($urandom_range(0, 20));
            1: distance = 16'($urandom_range(0, 4000));
            default: distance = 16'($urandom);
        endcase
        if (pick < 45)
            upsert(zoom, diop, $urandom_range(0, 4) == 0, 16'($urandom), 16'($urandom),
                   $urandom_range(0, 5) != 0);
        else if (pick < 92)
            lookup($urandom_range(0, 1) ? 16'($urandom) : zoom, distance,
                   $urandom_range(0, 4) == 0,
                   ($urandom_range(0, 2) == 0) ? 9'($urandom) : 9'd256);
        else if (pick < 95)
            issue_word(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                       9'($urandom));
        else
            issue_word(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                       9'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty table answers lookups with no data.
        lookup(16'h0100, 16'd1000, 1'b0, 9'd256);
        issue_word(OP_IGNORED, '1, '1, '1, 1'b1, '1, '1, 1'b1, '1);
        // A point that is not accepted leaves the table unloaded.
        upsert(16'h0200, 16'h0400, 1'b0, 16'sd1000, 16'h0100, 1'b0);
        lookup(16'h0200, 16'd1000, 1'b0, 9'd256);
        // Two layers with two zoom points each, extreme offsets and spreads.
        upsert(16'h0100, 16'h0400, 1'b0, 16'h7FFF, 16'hFFFF, 1'b1);
        upsert(16'h0400, 16'h0400, 1'b0, 16'h8000, 16'h0000, 1'b1);
        upsert(16'h0100, 16'h1000, 1'b0, -16'sd300, 16'h0200, 1'b1);
        upsert(16'h0400, 16'h1000, 1'b0, 16'sd700, 16'h0800, 1'b1);
        // Rewrite of an existing key.
        upsert(16'h0200, 16'h0400, 1'b0, 16'sd50, 16'h0080, 1'b1);
        // Inside both ranges, then beyond the zoom ends and beyond the diopter layers.
        lookup(16'h0300, 16'd500, 1'b0, 9'd256);
        lookup(16'h0000, 16'd0, 1'b0, 9'd256);
        lookup(16'hFFFF, 16'd1, 1'b0, 9'd128);
        lookup(16'h0180, 16'hFFFF, 1'b0, 9'd0);
        lookup(16'h0300, 16'd400, 1'b0, 9'h1FF);
        // The other direction has no accepted data yet.
        lookup(16'h0300, 16'd400, 1'b1, 9'd256);
        upsert(16'hFFFF, 16'hFFFF, 1'b1, 16'sd12, 16'h1234, 1'b1);
        lookup(16'h0000, 16'd3, 1'b1, 9'd256);
        issue_word(OP_CLEAR, '0, '0, '0, 1'b0, '0, '0, 1'b0, '0);
        lookup(16'h0300, 16'd400, 1'b0, 9'd256);
        // Fill the table to the brim; the last appends report it full.
        for (int i = 0; i < 34; i++)
            upsert(16'(i * 97), 16'(i * 1500), i[0], 16'($urandom), 16'($urandom), 1'b1);
        lookup(16'h0800, 16'd300, 1'b0, 9'd256);
        issue_word(OP_CLEAR, '0, '0, '0, 1'b0, '0, '0, 1'b0, '0);

        // Random part with idle bursts, calm at the end.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            random_word();
        end
        start <= 1'b0;

        while (words_in_flight != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/zdft_pkg.sv
hdl/zdft_div.sv
hdl/zoom_distance_focus_table.sv
bench/zdft_checker.sv
bench/tb_zoom_distance_focus_table.sv
